// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SRQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the house clock and reset names.
`define SRQ_ASSERT(label, prop, msg) \
  `SRQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/srq_pkg.sv
// Types, constants and helpers for the segment rotation queue.
`default_nettype none

package srq_pkg;

  localparam int unsigned RingSlots = 128;
  localparam int unsigned PtrW      = $clog2(RingSlots);
  localparam int unsigned IdW       = 31;
  localparam int unsigned LenW      = 32;
  localparam int unsigned StatusW   = 2;

  localparam logic [LenW-1:0] LimitReset = 32'd10240;

  localparam logic [StatusW-1:0] StatusOk     = 2'd0;
  localparam logic [StatusW-1:0] StatusFull   = 2'd1;
  localparam logic [StatusW-1:0] StatusNoData = 2'd2;

  localparam logic KindWrite = 1'b0;
  localparam logic KindRead  = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [LenW-1:0] write_length;
  } in_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     segment_id;
    logic               opened_new;
  } out_t;

  // Per-word result from the control stage; id comes from the ring when from_ring is set.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdW-1:0]     segment_id;
    logic               opened_new;
    logic               from_ring;
  } ctrl_res_t;

  typedef struct packed {
    logic            we;
    logic [PtrW-1:0] addr;
    logic [IdW-1:0]  data;
  } ring_wr_t;

  typedef struct packed {
    logic            re;
    logic [PtrW-1:0] addr;
  } ring_rd_t;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(RingSlots - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/srq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/srq_ctrl.sv
// Open segment, ring pointers, id counter and limit register; decides each word.
`default_nettype none

module srq_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          accept_i,
  input  wire srq_pkg::in_t                  in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [srq_pkg::LenW-1:0]      cfg_wdata_i,
  output srq_pkg::ctrl_res_t                 res_o,
  output srq_pkg::ring_wr_t                  ring_wr_o,
  output srq_pkg::ring_rd_t                  ring_rd_o
);

  logic [srq_pkg::PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [srq_pkg::IdW-1:0]  open_id_q, open_id_d, next_id_q, next_id_d;
  logic                     open_valid_q, open_valid_d;
  logic [srq_pkg::LenW-1:0] open_bytes_q, open_bytes_d, limit_q;

  logic                     is_write, is_read, replace, ring_full, ring_empty;
  logic                     reject, push, open_new, pop;
  logic [srq_pkg::LenW-1:0] base_bytes, sat_bytes;
  logic [srq_pkg::LenW:0]   sum;
  logic [srq_pkg::IdW-1:0]  cur_id;

  assign is_write   = (in_data_i.kind == srq_pkg::KindWrite);
  assign is_read    = (in_data_i.kind == srq_pkg::KindRead);
  assign replace    = !open_valid_q || (open_bytes_q == '0) || (open_bytes_q >= limit_q);
  assign ring_full  = (srq_pkg::ptr_next(tail_q) == head_q);
  assign ring_empty = (head_q == tail_q);

  assign reject   = is_write && replace && open_valid_q && ring_full;
  assign push     = is_write && replace && open_valid_q && !ring_full;
  assign open_new = is_write && replace && !reject;
  assign pop      = is_read && !ring_empty;

  assign cur_id     = open_new ? next_id_q : open_id_q;
  assign base_bytes = open_new ? '0 : open_bytes_q;
  assign sum        = {1'b0, base_bytes} + {1'b0, in_data_i.write_length};
  // saturate at all ones
  assign sat_bytes  = sum[srq_pkg::LenW] ? '1 : sum[srq_pkg::LenW-1:0];

  always_comb begin
    head_d       = head_q;
    tail_d       = tail_q;
    open_id_d    = open_id_q;
    next_id_d    = next_id_q;
    open_valid_d = open_valid_q;
    open_bytes_d = open_bytes_q;
    res_o        = '0;
    if (is_write) begin
      if (reject) begin
        res_o.status = srq_pkg::StatusFull;
      end else begin
        if (push) begin
          tail_d = srq_pkg::ptr_next(tail_q);
        end
        if (open_new) begin
          next_id_d = next_id_q + 1'b1;
        end
        open_id_d        = cur_id;
        open_valid_d     = 1'b1;
        open_bytes_d     = sat_bytes;
        res_o.segment_id = cur_id;
        res_o.opened_new = open_new;
      end
    end else begin
      if (pop) begin
        head_d          = srq_pkg::ptr_next(head_q);
        res_o.from_ring = 1'b1;
      end else if (open_valid_q) begin
        res_o.segment_id = open_id_q;
        open_valid_d     = 1'b0;
        open_bytes_d     = '0;
      end else begin
        res_o.status = srq_pkg::StatusNoData;
      end
    end
  end

  assign ring_wr_o.we   = accept_i && push;
  assign ring_wr_o.addr = tail_q;
  assign ring_wr_o.data = open_id_q;
  assign ring_rd_o.re   = accept_i && pop;
  assign ring_rd_o.addr = head_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      tail_q       <= '0;
      open_id_q    <= '0;
      next_id_q    <= '0;
      open_valid_q <= 1'b0;
      open_bytes_q <= '0;
    end else if (accept_i) begin
      head_q       <= head_d;
      tail_q       <= tail_d;
      open_id_q    <= open_id_d;
      next_id_q    <= next_id_d;
      open_valid_q <= open_valid_d;
      open_bytes_q <= open_bytes_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= srq_pkg::LimitReset;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/segment_rotation_queue.sv
// Segment rotation queue: top level with result pipeline and ring memory.
//
// Usage:
// - Input channel (in_valid_i/in_ready_o/in_data_i): one word per request,
//   kind selects write (add bytes to open segment) or read (pop oldest id).
// - Output channel (out_valid_o/out_ready_i/out_data_o): exactly one result
//   word per input word, in order.
// - cfg_we_i/cfg_wdata_i write the segment limit; write only while idle.
// - Pipeline: an accepted word is registered in the decision stage, then
//   moves to the output register once that is empty or being taken; the
//   ring read lands in between.
// - Throughput: one word per cycle while out_ready_i is high; state updates
//   resolve in the accept cycle; ring RAM: at most one write or read per word.
// - Stall: if the receiver holds ready low, the output register keeps its
//   word, the middle stage fills, then in_ready_o drops; nothing is lost.
// - Reset: pointers, open segment, id counter cleared, limit back to 10240.
//   The ring RAM is not cleared; entries are only read after being pushed,
//   so no clearing pass is needed and the block is ready right after reset.
`default_nettype none

`include "assert_macros.svh"

module segment_rotation_queue (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire srq_pkg::in_t             in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output srq_pkg::out_t                 out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [srq_pkg::LenW-1:0] cfg_wdata_i
);

  logic                    in_accept;
  logic                    s1_move;
  logic                    s1_valid_q, s1_valid_d;
  srq_pkg::ctrl_res_t      s1_res_q, ctrl_res;
  logic                    out_valid_q, out_valid_d;
  srq_pkg::out_t           out_q;
  srq_pkg::ring_wr_t       ring_wr;
  srq_pkg::ring_rd_t       ring_rd;
  logic [srq_pkg::IdW-1:0] ring_rdata;

  // middle stage drains when the output register is empty or being taken
  assign s1_move    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_accept  = in_valid_i && in_ready_o;

  srq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_o       (ctrl_res),
    .ring_wr_o   (ring_wr),
    .ring_rd_o   (ring_rd)
  );

  // read data holds until the next pop, so it survives a stall in stage 1
  srq_ram #(
    .Width (srq_pkg::IdW),
    .Depth (srq_pkg::RingSlots)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_wr.we),
    .waddr_i (ring_wr.addr),
    .wdata_i (ring_wr.data),
    .re_i    (ring_rd.re),
    .raddr_i (ring_rd.addr),
    .rdata_o (ring_rdata)
  );

  assign s1_valid_d  = in_accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_move ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_res_q <= ctrl_res;
    end
    if (s1_move) begin
      out_q.status     <= s1_res_q.status;
      out_q.segment_id <= s1_res_q.from_ring ? ring_rdata : s1_res_q.segment_id;
      out_q.opened_new <= s1_res_q.opened_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---- assertions ----
  `SRQ_ASSERT(a_ready_when_empty, !s1_valid_q |-> in_ready_o, "stage 1 empty but not ready")
  `SRQ_ASSERT(a_s1_holds,
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_res_q)),
    "stage 1 word lost during stall")
  `SRQ_ASSERT(a_err_fields_zero,
    (out_valid_o && out_data_o.status != srq_pkg::StatusOk) |->
      (out_data_o.segment_id == '0 && !out_data_o.opened_new),
    "error word carries id or open flag")
  `SRQ_ASSERT(a_ring_only_read,
    (s1_valid_q && s1_res_q.from_ring) |->
      (s1_res_q.status == srq_pkg::StatusOk && !s1_res_q.opened_new),
    "ring pop flagged on a bad word")

endmodule

`default_nettype wire
